@@ src/sha256_message_digest_top_macros.svh @@
// ----------------------------------------------------------------------------
// SHA-256 message digest: assertion macros
// Implication checks on the top-level clock and reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_DIGEST_TOP_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA2MD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA2MD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/sha2md_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 message digest: shared package
// Word types, core control struct, round constants and helper functions.
// ----------------------------------------------------------------------------
package sha2md_pkg;

   // Byte offset where the 64-bit length starts in the last block.
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   // Padding marker byte that follows the message.
   localparam logic [7:0] PAD_MARK   = 8'h80;

   // Input word.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic       shift_byte;
      logic [7:0] byte_val;
      logic       load;
      logic       round;
      logic [5:0] round_idx;
      logic       finish;
      logic       init;
      logic [2:0] rd_idx;
   } core_ctrl_type;

   function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] dbl;
      dbl  = {v, v} >> n;
      rotr = dbl[31:0];
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] v);
      big_sigma0 = rotr(v, 5'd2) ^ rotr(v, 5'd13) ^ rotr(v, 5'd22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] v);
      big_sigma1 = rotr(v, 5'd6) ^ rotr(v, 5'd11) ^ rotr(v, 5'd25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] v);
      small_sigma0 = rotr(v, 5'd7) ^ rotr(v, 5'd18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] v);
      small_sigma1 = rotr(v, 5'd17) ^ rotr(v, 5'd19) ^ (v >> 10);
   endfunction

   // Initial chaining value, H0 first.
   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      case (idx)
         3'd0: init_hash = 32'h6a09e667;
         3'd1: init_hash = 32'hbb67ae85;
         3'd2: init_hash = 32'h3c6ef372;
         3'd3: init_hash = 32'ha54ff53a;
         3'd4: init_hash = 32'h510e527f;
         3'd5: init_hash = 32'h9b05688c;
         3'd6: init_hash = 32'h1f83d9ab;
         default: init_hash = 32'h5be0cd19;
      endcase
   endfunction

   // Round constants.
   function automatic logic [31:0] round_const(input logic [5:0] idx);
      case (idx)
         6'd0:  round_const = 32'h428a2f98;
         6'd1:  round_const = 32'h71374491;
         6'd2:  round_const = 32'hb5c0fbcf;
         6'd3:  round_const = 32'he9b5dba5;
         6'd4:  round_const = 32'h3956c25b;
         6'd5:  round_const = 32'h59f111f1;
         6'd6:  round_const = 32'h923f82a4;
         6'd7:  round_const = 32'hab1c5ed5;
         6'd8:  round_const = 32'hd807aa98;
         6'd9:  round_const = 32'h12835b01;
         6'd10: round_const = 32'h243185be;
         6'd11: round_const = 32'h550c7dc3;
         6'd12: round_const = 32'h72be5d74;
         6'd13: round_const = 32'h80deb1fe;
         6'd14: round_const = 32'h9bdc06a7;
         6'd15: round_const = 32'hc19bf174;
         6'd16: round_const = 32'he49b69c1;
         6'd17: round_const = 32'hefbe4786;
         6'd18: round_const = 32'h0fc19dc6;
         6'd19: round_const = 32'h240ca1cc;
         6'd20: round_const = 32'h2de92c6f;
         6'd21: round_const = 32'h4a7484aa;
         6'd22: round_const = 32'h5cb0a9dc;
         6'd23: round_const = 32'h76f988da;
         6'd24: round_const = 32'h983e5152;
         6'd25: round_const = 32'ha831c66d;
         6'd26: round_const = 32'hb00327c8;
         6'd27: round_const = 32'hbf597fc7;
         6'd28: round_const = 32'hc6e00bf3;
         6'd29: round_const = 32'hd5a79147;
         6'd30: round_const = 32'h06ca6351;
         6'd31: round_const = 32'h14292967;
         6'd32: round_const = 32'h27b70a85;
         6'd33: round_const = 32'h2e1b2138;
         6'd34: round_const = 32'h4d2c6dfc;
         6'd35: round_const = 32'h53380d13;
         6'd36: round_const = 32'h650a7354;
         6'd37: round_const = 32'h766a0abb;
         6'd38: round_const = 32'h81c2c92e;
         6'd39: round_const = 32'h92722c85;
         6'd40: round_const = 32'ha2bfe8a1;
         6'd41: round_const = 32'ha81a664b;
         6'd42: round_const = 32'hc24b8b70;
         6'd43: round_const = 32'hc76c51a3;
         6'd44: round_const = 32'hd192e819;
         6'd45: round_const = 32'hd6990624;
         6'd46: round_const = 32'hf40e3585;
         6'd47: round_const = 32'h106aa070;
         6'd48: round_const = 32'h19a4c116;
         6'd49: round_const = 32'h1e376c08;
         6'd50: round_const = 32'h2748774c;
         6'd51: round_const = 32'h34b0bcb5;
         6'd52: round_const = 32'h391c0cb3;
         6'd53: round_const = 32'h4ed8aa4a;
         6'd54: round_const = 32'h5b9cca4f;
         6'd55: round_const = 32'h682e6ff3;
         6'd56: round_const = 32'h748f82ee;
         6'd57: round_const = 32'h78a5636f;
         6'd58: round_const = 32'h84c87814;
         6'd59: round_const = 32'h8cc70208;
         6'd60: round_const = 32'h90befffa;
         6'd61: round_const = 32'ha4506ceb;
         6'd62: round_const = 32'hbef9a3f7;
         default: round_const = 32'hc67178f2;
      endcase
   endfunction

endpackage

@@ src/sha2md_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 compression datapath
// Block shift line, message schedule, one round per cycle, chaining value.
// ----------------------------------------------------------------------------
module sha2md_core (
   input  logic                         clock,
   input  logic                         reset,
   input  sha2md_pkg::core_ctrl_type    ctrl,
   output logic [31:0]                  rd_data
);

   // Block buffer and schedule window share one 16-word shift line.
   // Word 0 is the oldest word and sits in the top bits.
   logic [511:0] win_ff, win_in;

   // Working variables a..h.
   logic [31:0] va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff, vh_ff;

   // Chaining value, H0 at index 0.
   logic [31:0] chain_ff [8];

   logic [31:0] w0, w1, w9, w14, w_new;
   logic [31:0] t1, t2;

   // Fixed schedule taps.
   assign w0  = win_ff[511:480];
   assign w1  = win_ff[479:448];
   assign w9  = win_ff[223:192];
   assign w14 = win_ff[63:32];
   assign w_new = sha2md_pkg::small_sigma1(w14) + w9 + sha2md_pkg::small_sigma0(w1) + w0;

   // Round function.
   assign t1 = vh_ff + sha2md_pkg::big_sigma1(ve_ff) + ((ve_ff & vf_ff) ^ (~ve_ff & vg_ff))
             + sha2md_pkg::round_const(ctrl.round_idx) + w0;
   assign t2 = sha2md_pkg::big_sigma0(va_ff)
             + ((va_ff & vb_ff) ^ (va_ff & vc_ff) ^ (vb_ff & vc_ff));

   // Shift line next value: a byte while filling, a word per round.
   always_comb begin
      win_in = win_ff;
      if (ctrl.shift_byte) begin
         win_in = {win_ff[503:0], ctrl.byte_val};
      end else if (ctrl.round) begin
         win_in = {win_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   // Working variables load from the chaining value, then step once a round.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         va_ff <= chain_ff[0];
         vb_ff <= chain_ff[1];
         vc_ff <= chain_ff[2];
         vd_ff <= chain_ff[3];
         ve_ff <= chain_ff[4];
         vf_ff <= chain_ff[5];
         vg_ff <= chain_ff[6];
         vh_ff <= chain_ff[7];
      end else if (ctrl.round) begin
         va_ff <= t1 + t2;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff + t1;
         vf_ff <= ve_ff;
         vg_ff <= vf_ff;
         vh_ff <= vg_ff;
      end
   end

   // Chaining value: initial hash after reset or a finished message,
   // folded with the working variables at the end of each block.
   always_ff @(posedge clock) begin
      if (reset || ctrl.init) begin
         for (int k = 0; k < 8; k++) begin
            chain_ff[k] <= sha2md_pkg::init_hash(3'(k));
         end
      end else if (ctrl.finish) begin
         chain_ff[0] <= chain_ff[0] + va_ff;
         chain_ff[1] <= chain_ff[1] + vb_ff;
         chain_ff[2] <= chain_ff[2] + vc_ff;
         chain_ff[3] <= chain_ff[3] + vd_ff;
         chain_ff[4] <= chain_ff[4] + ve_ff;
         chain_ff[5] <= chain_ff[5] + vf_ff;
         chain_ff[6] <= chain_ff[6] + vg_ff;
         chain_ff[7] <= chain_ff[7] + vh_ff;
      end
   end

   assign rd_data = chain_ff[ctrl.rd_idx];

endmodule

@@ src/sha256_message_digest_top.sv @@
// ----------------------------------------------------------------------------
// SHA-256 message digest, top level
// Streams message bytes, pads the message and returns the eight digest words.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                 payload
//   req       in          req_valid / req_ready     req_data  (sha2md_pkg::req_type)
//   rsp       out         rsp_valid / rsp_ready     rsp_data  (sha2md_pkg::rsp_type)
//
// The byte that fills a block starts a compression: 64 rounds on the shared
// round unit, then one chaining fold. A final word pads up to the block end
// and compresses one or two blocks, then the eight digest words are loaded
// into the output register in turn.
// req_ready is high only while the sequencer is idle.
// The digest is held in one output register; a stall on rsp holds the sequencer.
// Reset is synchronous and restores the initial hash and an empty buffer.
//
module sha256_message_digest_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sha2md_pkg::req_type   req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sha2md_pkg::rsp_type   rsp_data
);

   `include "sha256_message_digest_top_macros.svh"

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_COMP = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] count_ff, count_in;
   logic [5:0]  round_ff, round_in;
   logic        pad_ff, pad_in;
   logic        sent80_ff, sent80_in;
   logic        len_ok_ff, len_ok_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sha2md_pkg::rsp_type rsp_data_ff, rsp_data_in;

   sha2md_pkg::core_ctrl_type ctrl;
   logic [31:0] rd_data;
   logic [63:0] len_shift;
   logic [7:0]  pad_byte;
   logic        out_load;

   sha2md_core u_core (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .rd_data (rd_data)
   );

   // Padding byte: marker first, then zeros, with the length in the last eight bytes.
   assign len_shift = count_ff << {fill_ff[2:0], 3'b000};
   always_comb begin
      if (!sent80_ff) begin
         pad_byte = sha2md_pkg::PAD_MARK;
      end else if (len_ok_ff && (fill_ff >= sha2md_pkg::LEN_OFFSET)) begin
         pad_byte = len_shift[63:56];
      end else begin
         pad_byte = 8'h00;
      end
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      round_in   = round_ff;
      pad_in     = pad_ff;
      sent80_in  = sent80_ff;
      len_ok_in  = len_ok_ff;
      out_idx_in = out_idx_ff;
      out_load   = 1'b0;
      ctrl       = '0;
      ctrl.rd_idx    = out_idx_ff;
      ctrl.round_idx = round_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pad_in    = req_data.end_of_message;
               sent80_in = 1'b0;
               len_ok_in = 1'b0;
               if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
               if (req_data.has_byte) begin
                  ctrl.shift_byte = 1'b1;
                  ctrl.byte_val   = req_data.data_byte;
                  count_in        = count_ff + 64'd8;
                  fill_in         = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     ctrl.load = 1'b1;
                     round_in  = 6'd0;
                     state_in  = ST_COMP;
                  end
               end
            end
         end
         ST_PAD: begin
            ctrl.shift_byte = 1'b1;
            ctrl.byte_val   = pad_byte;
            fill_in         = fill_ff + 6'd1;
            if (!sent80_ff) begin
               sent80_in = 1'b1;
               len_ok_in = (fill_ff < sha2md_pkg::LEN_OFFSET);
            end
            if (fill_ff == 6'd63) begin
               ctrl.load = 1'b1;
               round_in  = 6'd0;
               state_in  = ST_COMP;
            end
         end
         ST_COMP: begin
            ctrl.round = 1'b1;
            round_in   = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            ctrl.finish = 1'b1;
            if (pad_ff && sent80_ff && len_ok_ff) begin
               out_idx_in = 3'd0;
               state_in   = ST_OUT;
            end else if (pad_ff) begin
               if (sent80_ff) begin
                  len_ok_in = 1'b1;
               end
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load   = 1'b1;
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  ctrl.init = 1'b1;
                  count_in  = 64'd0;
                  fill_in   = 6'd0;
                  pad_in    = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register.
   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_ready);
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (out_load) begin
         rsp_data_in.digest_word = rd_data;
         rsp_data_in.word_index  = out_idx_ff;
         rsp_data_in.last_word   = (out_idx_ff == 3'd7);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= 6'd0;
         count_ff     <= 64'd0;
         round_ff     <= 6'd0;
         pad_ff       <= 1'b0;
         sent80_ff    <= 1'b0;
         len_ok_ff    <= 1'b0;
         out_idx_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         round_ff     <= round_in;
         pad_ff       <= pad_in;
         sent80_ff    <= sent80_in;
         len_ok_ff    <= len_ok_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The last round always hands over to the chaining fold.
   `SHA2MD_ASSERT_NEXT(a_round_end, (state_ff == ST_COMP) && (round_ff == 6'd63), state_ff == ST_FIN, "last round not followed by fold")
   // A block is only compressed once the buffer has wrapped to empty.
   `SHA2MD_ASSERT_SAME(a_fold_empty, state_ff == ST_FIN, fill_ff == 6'd0, "fold with partial block")
   // After the last digest word the message state is back to empty.
   `SHA2MD_ASSERT_NEXT(a_msg_reset, out_load && (out_idx_ff == 3'd7), (count_ff == 64'd0) && (state_ff == ST_IDLE) && rsp_data_ff.last_word, "message state not cleared after digest")

endmodule

@@ tb/tb_sha256_message_digest_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 message digest testbench
// Streams byte words into the digest engine, directed first and then as random
// messages of many lengths, with random gaps and stalls on both channels. A
// built-in SHA-256 predictor, or a digest typed in where it is well known,
// gives the eight words of each digest, compared field by field in order.
// ----------------------------------------------------------------------------
module tb_sha256_message_digest_top;

   localparam int   HALF_PERIOD = 5;
   localparam int   RESET_CYCLES = 5;
   localparam int   TARGET_ITEMS = 420;
   localparam int   MAX_IDLE = 17;
   localparam int   DRAIN_CYCLES = 300;
   localparam int   WATCHDOG_LIMIT = 4000;
   localparam int   BLOCK_BYTES = 64;
   localparam int   LENGTH_POS = 56;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Well-known digests of the empty message and of "abc".
   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

   localparam logic [0:7][31:0] HASH_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [0:63][31:0] ROUND_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // One directed word, with the digest typed in where it is well known.
   typedef struct packed {
      sha2md_pkg::req_type word;
      logic                known;
      logic [255:0]        digest;
   } stim_row_type;

   localparam int NUM_ROWS = 17;
   stim_row_type directed_rows [NUM_ROWS] = '{
      {8'hff, 1'b0, 1'b0, 1'b0, 256'h0},          // idle word with stray data
      {8'h5a, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},    // empty message
      {8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
      {8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},      // last byte rides on the end word
      {8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'h63, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'hff, 1'b0, 1'b1, 1'b1, ABC_DIGEST},      // end word without a byte
      {8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
      {8'haa, 1'b0, 1'b0, 1'b0, 256'h0},
      {8'h80, 1'b1, 1'b1, 1'b0, 256'h0},
      {8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
      {8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
      {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
   };

   localparam int NUM_EDGE_LENGTHS = 10;
   localparam int EDGE_LENGTHS [NUM_EDGE_LENGTHS] =
      '{55, 56, 57, 62, 63, 64, 65, 119, 120, 128};

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   sha2md_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   sha2md_pkg::rsp_type rsp_data;

   // Predictor state: chaining value, partial block and running bit count.
   logic [31:0] chain_words [8];
   logic [7:0]  block_bytes [BLOCK_BYTES];
   int          block_fill;
   logic [63:0] msg_bits;
   logic [31:0] final_digest [8];

   sha2md_pkg::rsp_type digest_words_q [$];
   int          error_count = 0;
   int          words_checked = 0;
   int          messages_sent = 0;
   int          items_sent = 0;
   int          idle_sent = 0;
   int          quiet_cycles = 0;
   bit          tx_gapless = 0;
   bit          rx_gapless = 0;

   sha256_message_digest_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

   task automatic hash_init();
      for (int k = 0; k < 8; k++) chain_words[k] = HASH_IV[k];
      block_fill = 0;
      msg_bits = '0;
   endtask

   // One 64-round compression of the buffered block into the chaining value.
   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int r = 0; r < 16; r++) begin
         w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                 block_bytes[4*r+3]};
      end
      for (int r = 16; r < 64; r++) begin
         s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
         s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
         w[r] = s1 + w[r-7] + s0 + w[r-16];
      end
      for (int k = 0; k < 8; k++) v[k] = chain_words[k];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
              ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
              ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int k = 0; k < 8; k++) chain_words[k] = chain_words[k] + v[k];
   endtask

   // Absorb one word; on the end of a message pad, finish and latch the digest.
   task automatic hash_absorb(input sha2md_pkg::req_type it, output bit done);
      done = 1'b0;
      if (it.has_byte) begin
         block_bytes[block_fill] = it.data_byte;
         block_fill++;
         msg_bits = msg_bits + 64'd8;
         if (block_fill == BLOCK_BYTES) begin
            compress_block();
            block_fill = 0;
         end
      end
      if (it.end_of_message) begin
         block_bytes[block_fill] = PAD_BYTE;
         block_fill++;
         // No room left for the length: it goes into one more block.
         if (block_fill > LENGTH_POS) begin
            while (block_fill < BLOCK_BYTES) begin
               block_bytes[block_fill] = 8'h00;
               block_fill++;
            end
            compress_block();
            block_fill = 0;
         end
         while (block_fill < LENGTH_POS) begin
            block_bytes[block_fill] = 8'h00;
            block_fill++;
         end
         for (int k = 0; k < 8; k++) block_bytes[LENGTH_POS + k] = msg_bits[63 - 8*k -: 8];
         compress_block();
         for (int k = 0; k < 8; k++) final_digest[k] = chain_words[k];
         hash_init();
         done = 1'b1;
      end
   endtask

   // Present one word after a random gap, wait for it to be taken, then queue
   // the digest words it finishes. Entered and left at a falling edge.
   task automatic send_word(input sha2md_pkg::req_type it, input bit known,
                            input logic [255:0] golden);
      int                  gap;
      bit                  done;
      sha2md_pkg::rsp_type exp_word;
      gap = tx_gapless ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!(req_valid && req_ready));
      hash_absorb(it, done);
      if (done) begin
         for (int k = 0; k < 8; k++) begin
            exp_word.digest_word = known ? golden[255 - 32*k -: 32] : final_digest[k];
            exp_word.word_index  = 3'(k);
            exp_word.last_word   = (k == 7);
            digest_words_q = {digest_words_q, exp_word};
         end
         messages_sent++;
      end
      if (it.has_byte || it.end_of_message) items_sent++;
      else idle_sent++;
      @(negedge clock);
   endtask

   // Result checker: every accepted word against the oldest expectation.
   always @(posedge clock) begin
      sha2md_pkg::rsp_type exp_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_words_q.size() == 0) begin
            $error("unexpected digest word %h (index %0d)", rsp_data.digest_word,
                   rsp_data.word_index);
            error_count++;
         end else begin
            exp_word = digest_words_q.pop_front();
            words_checked++;
            if (rsp_data.digest_word !== exp_word.digest_word) begin
               $error("digest_word mismatch: expected %h, actual %h",
                      exp_word.digest_word, rsp_data.digest_word);
               error_count++;
            end
            if (rsp_data.word_index !== exp_word.word_index) begin
               $error("word_index mismatch: expected %0d, actual %0d",
                      exp_word.word_index, rsp_data.word_index);
               error_count++;
            end
            if (rsp_data.last_word !== exp_word.last_word) begin
               $error("last_word mismatch: expected %b, actual %b",
                      exp_word.last_word, rsp_data.last_word);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Result side: random stalls before each word, with gapless stretches.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_gapless = ($urandom_range(0, 2) == 0);
         stall = rx_gapless ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Stimulus: reset, directed table, then random messages.
   initial begin
      int                  msg_len;
      int                  pick;
      bit                  byte_on_end;
      sha2md_pkg::req_type it;
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      hash_init();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].digest);
      end

      while (items_sent + idle_sent < TARGET_ITEMS) begin
         // Short messages most often, some medium, some on block and padding edges.
         pick = $urandom_range(0, 9);
         if (pick < 4) msg_len = $urandom_range(0, 8);
         else if (pick < 7) msg_len = $urandom_range(9, 70);
         else msg_len = EDGE_LENGTHS[$urandom_range(0, NUM_EDGE_LENGTHS - 1)];
         byte_on_end = (msg_len > 0) && ($urandom_range(0, 1) == 1);
         tx_gapless  = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < msg_len - (byte_on_end ? 1 : 0); i++) begin
            if ($urandom_range(0, 11) == 0) begin
               it.data_byte      = 8'($urandom_range(0, 255));
               it.has_byte       = 1'b0;
               it.end_of_message = 1'b0;
               send_word(it, 1'b0, '0);
            end
            it.data_byte      = 8'($urandom_range(0, 255));
            it.has_byte       = 1'b1;
            it.end_of_message = 1'b0;
            send_word(it, 1'b0, '0);
         end
         it.data_byte      = 8'($urandom_range(0, 255));
         it.has_byte       = byte_on_end;
         it.end_of_message = 1'b1;
         send_word(it, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (digest_words_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d byte and end words (%0d idle words) forming %0d messages,",
               items_sent, idle_sent, messages_sent);
      $display("including empty, block-boundary and padding-overflow lengths; %0d words checked.",
               words_checked);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
